### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ck, rstn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/aad_pkg.sv
package aad_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_HEIGHT = 2'd3;

  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DGO,
    S_DWT,
    S_INIT,
    S_RD,
    S_MAC,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_XF,
    OP_XL,
    OP_YF,
    OP_YL,
    OP_AVG
  } div_op_t;

endpackage

### sv/area_average_downscaler_unit.sv
// A pixel write is a one-cycle transfer; the block is ready again in the next cycle.
// An in-range request runs four divisions on the shared serial divider (22-bit dividend
// at default sizes) for the edges, walks the Nx by Ny source window under the cell,
// reading and accumulating each pixel, and divides the sum for the average. out_valid
// rises once the output register is free, with in_ready in the same cycle. A request
// outside the target skips the divisions. Reset is synchronous and active low; it sets
// all size registers to 64 and clears control state. The source memory is not cleared.
`include "assert_macros.svh"

module area_average_downscaler_unit #(
  parameter int MAX_SOURCE_DIM = 128,
  parameter int TARGET_SIZE    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [6:0]                    in_src_col,
  input  logic [6:0]                    in_src_row,
  input  logic [7:0]                    in_src_pixel,
  input  logic [5:0]                    in_dst_col,
  input  logic [5:0]                    in_dst_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_avg_value,
  output logic [5:0]                    out_echo_col,
  output logic [5:0]                    out_echo_row
);

  import aad_pkg::*;

  localparam int SW_W   = $clog2(MAX_SOURCE_DIM + 1);
  localparam int TW_W   = $clog2(TARGET_SIZE + 1);
  localparam int IX_W   = $clog2(MAX_SOURCE_DIM);
  localparam int AW     = $clog2(MAX_SOURCE_DIM * MAX_SOURCE_DIM);
  localparam int CO_W   = $clog2(TARGET_SIZE * MAX_SOURCE_DIM + 1);
  localparam int TOT_W  = $clog2(MAX_SOURCE_DIM * MAX_SOURCE_DIM + 1);
  localparam int SUM_W  = $clog2(255 * MAX_SOURCE_DIM * MAX_SOURCE_DIM + 1);
  localparam int W_W    = 2 * TW_W;
  localparam int PROD_W = 8 + W_W;
  localparam int DV_W   = (SUM_W > CO_W) ? SUM_W : CO_W;
  localparam int DS_W   = (TOT_W > TW_W) ? TOT_W : TW_W;

  state_t  state_r, state_nxt;
  div_op_t op_r;

  logic [7:0] src_width_r, src_height_r;
  logic [6:0] tgt_width_r, tgt_height_r;

  logic [SW_W-1:0] sw_eff, sh_eff;
  logic [TW_W-1:0] tw_eff, th_eff;

  logic in_xfer, req_in_range, mem_we;
  logic div_start, div_done;
  logic [DV_W-1:0] div_dvd, div_quot;
  logic [DS_W-1:0] div_dsr;

  logic [5:0]  col_r, row_r;
  logic [7:0]  avg_r;
  logic [CO_W-1:0] x0_r, y0_r, x1, y1;
  logic [IX_W-1:0] sx_first_r, sx_last_r, sy_first_r, sy_last_r, sx_r, sy_r;
  logic [CO_W-1:0] sx_lo_r, sy_lo_r, sx_lo_first_r;
  logic [CO_W-1:0] sx_hi, sy_hi, x_top, x_bot, y_top, y_bot;
  logic [TW_W-1:0] ox, oy;
  logic [W_W-1:0]  w_r;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum_r;
  logic [7:0]  rd_data_r;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]  mem [MAX_SOURCE_DIM * MAX_SOURCE_DIM];

  logic       out_valid_r;
  logic [7:0] out_avg_r;
  logic [5:0] out_col_r, out_row_r;

  // Effective sizes, saturated to their legal ranges.
  always_comb begin
    sw_eff = (src_width_r == '0) ? SW_W'(1) :
             ((32'(src_width_r) > MAX_SOURCE_DIM) ? SW_W'(MAX_SOURCE_DIM) : SW_W'(src_width_r));
    sh_eff = (src_height_r == '0) ? SW_W'(1) :
             ((32'(src_height_r) > MAX_SOURCE_DIM) ? SW_W'(MAX_SOURCE_DIM) : SW_W'(src_height_r));
    tw_eff = (tgt_width_r == '0) ? TW_W'(1) :
             ((32'(tgt_width_r) > TARGET_SIZE) ? TW_W'(TARGET_SIZE) : TW_W'(tgt_width_r));
    th_eff = (tgt_height_r == '0) ? TW_W'(1) :
             ((32'(tgt_height_r) > TARGET_SIZE) ? TW_W'(TARGET_SIZE) : TW_W'(tgt_height_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= 8'd64;
      src_height_r <= 8'd64;
      tgt_width_r  <= 7'd64;
      tgt_height_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data;
        CFG_SRC_HEIGHT: src_height_r <= cfg_data;
        CFG_TGT_WIDTH:  tgt_width_r  <= cfg_data[6:0];
        CFG_TGT_HEIGHT: tgt_height_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign in_xfer      = in_valid && in_ready;
  assign req_in_range = (32'(in_dst_col) < 32'(tw_eff)) && (32'(in_dst_row) < 32'(th_eff));
  assign mem_we       = in_xfer && (in_kind == KIND_WRITE) &&
                        (32'(in_src_col) < MAX_SOURCE_DIM) && (32'(in_src_row) < MAX_SOURCE_DIM);
  assign wr_addr      = AW'(32'(in_src_row) * MAX_SOURCE_DIM + 32'(in_src_col));
  assign rd_addr      = AW'(32'(sy_r) * MAX_SOURCE_DIM + 32'(sx_r));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_src_pixel;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Overlap of the current source pixel with the cell, per axis.
  always_comb begin
    x1    = CO_W'(x0_r + CO_W'(sw_eff));
    y1    = CO_W'(y0_r + CO_W'(sh_eff));
    sx_hi = CO_W'(sx_lo_r + CO_W'(tw_eff));
    sy_hi = CO_W'(sy_lo_r + CO_W'(th_eff));
    x_top = (sx_hi < x1) ? sx_hi : x1;
    x_bot = (sx_lo_r > x0_r) ? sx_lo_r : x0_r;
    y_top = (sy_hi < y1) ? sy_hi : y1;
    y_bot = (sy_lo_r > y0_r) ? sy_lo_r : y0_r;
    ox    = TW_W'(x_top - x_bot);
    oy    = TW_W'(y_top - y_bot);
    prod  = PROD_W'(rd_data_r) * PROD_W'(w_r);
  end

  always_comb begin
    case (op_r)
      OP_XF: begin
        div_dvd = DV_W'(x0_r);
        div_dsr = DS_W'(tw_eff);
      end
      OP_XL: begin
        div_dvd = DV_W'(CO_W'(x1 - CO_W'(1)));
        div_dsr = DS_W'(tw_eff);
      end
      OP_YF: begin
        div_dvd = DV_W'(y0_r);
        div_dsr = DS_W'(th_eff);
      end
      OP_YL: begin
        div_dvd = DV_W'(CO_W'(y1 - CO_W'(1)));
        div_dsr = DS_W'(th_eff);
      end
      OP_AVG: begin
        div_dvd = DV_W'(sum_r);
        div_dsr = DS_W'(TOT_W'(sw_eff) * TOT_W'(sh_eff));
      end
      default: begin
        div_dvd = '0;
        div_dsr = DS_W'(1);
      end
    endcase
  end

  aad_div #(
    .DVD_W(DV_W),
    .DSR_W(DS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_kind == KIND_REQUEST) begin
          state_nxt = req_in_range ? S_DGO : S_DONE;
        end
      end
      S_DGO: state_nxt = S_DWT;
      S_DWT: begin
        if (div_done) begin
          if (op_r == OP_YL) begin
            state_nxt = S_INIT;
          end else if (op_r == OP_AVG) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DGO;
          end
        end
      end
      S_INIT: state_nxt = S_RD;
      S_RD:   state_nxt = S_MAC;
      S_MAC: begin
        state_nxt = (sx_r == sx_last_r && sy_r == sy_last_r) ? S_DGO : S_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    div_start = (state_r == S_DGO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_kind == KIND_REQUEST) begin
          col_r <= in_dst_col;
          row_r <= in_dst_row;
          op_r  <= OP_XF;
          avg_r <= '0;
          x0_r  <= CO_W'(in_dst_col) * CO_W'(sw_eff);
          y0_r  <= CO_W'(in_dst_row) * CO_W'(sh_eff);
        end
      end
      S_DWT: begin
        if (div_done) begin
          case (op_r)
            OP_XF: begin
              sx_first_r <= IX_W'(div_quot);
              op_r       <= OP_XL;
            end
            OP_XL: begin
              sx_last_r <= IX_W'(div_quot);
              op_r      <= OP_YF;
            end
            OP_YF: begin
              sy_first_r <= IX_W'(div_quot);
              op_r       <= OP_YL;
            end
            OP_YL: sy_last_r <= IX_W'(div_quot);
            OP_AVG: avg_r <= (div_quot > DV_W'(255)) ? 8'hFF : div_quot[7:0];
            default: ;
          endcase
        end
      end
      S_INIT: begin
        sx_r          <= sx_first_r;
        sy_r          <= sy_first_r;
        sx_lo_r       <= CO_W'(sx_first_r) * CO_W'(tw_eff);
        sx_lo_first_r <= CO_W'(sx_first_r) * CO_W'(tw_eff);
        sy_lo_r       <= CO_W'(sy_first_r) * CO_W'(th_eff);
        sum_r         <= '0;
      end
      S_RD: w_r <= W_W'(ox) * W_W'(oy);
      S_MAC: begin
        sum_r <= SUM_W'(sum_r + SUM_W'(prod));
        if (sx_r == sx_last_r) begin
          if (sy_r == sy_last_r) begin
            op_r <= OP_AVG;
          end else begin
            sx_r    <= sx_first_r;
            sx_lo_r <= sx_lo_first_r;
            sy_r    <= IX_W'(sy_r + IX_W'(1));
            sy_lo_r <= CO_W'(sy_lo_r + CO_W'(th_eff));
          end
        end else begin
          sx_r    <= IX_W'(sx_r + IX_W'(1));
          sx_lo_r <= CO_W'(sx_lo_r + CO_W'(tw_eff));
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_avg_r <= avg_r;
          out_col_r <= col_r;
          out_row_r <= row_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_avg_value = out_avg_r;
  assign out_echo_col  = out_col_r;
  assign out_echo_row  = out_row_r;

  `ASSERT_SAME(a_div_done_in_wait, clk, rst_n, div_done, state_r == S_DWT,
               "Divider finished outside its wait state.")
  `ASSERT_NEXT(a_req_starts_div, clk, rst_n,
               in_xfer && in_kind == KIND_REQUEST && req_in_range,
               state_r == S_DGO && op_r == OP_XF,
               "An in-range request did not start the first division.")
  `ASSERT_SAME(a_walk_in_window, clk, rst_n, state_r == S_MAC,
               sx_r <= sx_last_r && sy_r <= sy_last_r,
               "Source walk left the cell window.")
  `ASSERT_SAME(a_result_from_done, clk, rst_n, $rose(out_valid_r),
               $past(state_r) == S_DONE,
               "A result transfer appeared without a finished request.")

endmodule

### sv/aad_div.sv
module aad_div #(
  parameter int DVD_W = 23,
  parameter int DSR_W = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DVD_W-1:0] dq_r;
  logic [DSR_W:0]   shifted;
  logic             fits;
  logic [DSR_W-1:0] rem_nxt;
  logic [DVD_W-1:0] dq_nxt;

  always_comb begin
    shifted = {rem_r, dq_r[DVD_W-1]};
    fits    = shifted >= {1'b0, dsr_r};
    rem_nxt = fits ? DSR_W'(shifted - {1'b0, dsr_r}) : DSR_W'(shifted);
    dq_nxt  = {dq_r[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CNT_W'(DVD_W);
      rem_r <= '0;
      dsr_r <= divisor;
      dq_r  <= dividend;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

### tb/area_average_downscaler_unit_check.sv
`timescale 1ns / 100ps

module area_average_downscaler_unit_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_kind,
  input  logic [6:0]                    in_src_col,
  input  logic [6:0]                    in_src_row,
  input  logic [7:0]                    in_src_pixel,
  input  logic [5:0]                    in_dst_col,
  input  logic [5:0]                    in_dst_row,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [7:0]                    out_avg_value,
  input  logic [5:0]                    out_echo_col,
  input  logic [5:0]                    out_echo_row,
  output int                            mismatches,
  output int                            outstanding
);
  import aad_pkg::*;

  localparam int unsigned SRC_DIM_MAX = 128;
  localparam int unsigned TGT_DIM_MAX = 64;

  typedef struct packed {
    logic [7:0] avg;
    logic [5:0] col;
    logic [5:0] row;
  } cell_result_t;

  logic [7:0]   src_pixels [0:SRC_DIM_MAX*SRC_DIM_MAX-1];
  logic [7:0]   src_w_reg;
  logic [7:0]   src_h_reg;
  logic [6:0]   tgt_w_reg;
  logic [6:0]   tgt_h_reg;
  cell_result_t cell_results_q[$];
  int           err_count = 0;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned span_overlap(int unsigned lo_a, int unsigned hi_a,
                                               int unsigned lo_b, int unsigned hi_b);
    return ((hi_a < hi_b) ? hi_a : hi_b) - ((lo_a > lo_b) ? lo_a : lo_b);
  endfunction

  // Cell edges are kept in units of 1/tw (x) and 1/th (y) of a source pixel,
  // so every overlap weight is an exact integer.
  function automatic logic [7:0] cell_average(int unsigned x, int unsigned y);
    int unsigned     sw, sh, tw, th;
    int unsigned     x0, x1, y0, y1, sx, sy, ox, oy;
    longint unsigned acc, wsum, quot;
    sw = clamp_dim(src_w_reg, SRC_DIM_MAX);
    sh = clamp_dim(src_h_reg, SRC_DIM_MAX);
    tw = clamp_dim(tgt_w_reg, TGT_DIM_MAX);
    th = clamp_dim(tgt_h_reg, TGT_DIM_MAX);
    if (x >= tw || y >= th) return 8'd0;
    x0 = x * sw;
    x1 = (x + 1) * sw;
    y0 = y * sh;
    y1 = (y + 1) * sh;
    acc = 0;
    wsum = 0;
    for (sy = y0 / th; sy <= (y1 - 1) / th && sy < sh; sy++) begin
      oy = span_overlap(sy * th, (sy + 1) * th, y0, y1);
      for (sx = x0 / tw; sx <= (x1 - 1) / tw && sx < sw; sx++) begin
        ox = span_overlap(sx * tw, (sx + 1) * tw, x0, x1);
        acc += longint'(src_pixels[sy * SRC_DIM_MAX + sx]) * ox * oy;
        wsum += longint'(ox) * oy;
      end
    end
    quot = (wsum != 0) ? acc / wsum : 0;
    if (quot > 255) quot = 255;
    return quot[7:0];
  endfunction

  always @(posedge clk) begin : track
    cell_result_t got;
    cell_result_t want;
    if (!rst_n) begin
      src_w_reg <= 8'd64;
      src_h_reg <= 8'd64;
      tgt_w_reg <= 7'd64;
      tgt_h_reg <= 7'd64;
      cell_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_WIDTH: src_w_reg <= cfg_data;
          CFG_SRC_HEIGHT: src_h_reg <= cfg_data;
          CFG_TGT_WIDTH: tgt_w_reg <= cfg_data[6:0];
          CFG_TGT_HEIGHT: tgt_h_reg <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_WRITE) begin
          src_pixels[{in_src_row, in_src_col}] <= in_src_pixel;
        end else begin
          cell_results_q.push_back(cell_result_t'{cell_average(in_dst_col, in_dst_row),
                                                  in_dst_col, in_dst_row});
        end
      end
      if (out_valid && out_ready) begin
        got = cell_result_t'{out_avg_value, out_echo_col, out_echo_row};
        if (cell_results_q.size() == 0) begin
          $display("%0t: unexpected result transfer: avg %0d col %0d row %0d",
                   $time, got.avg, got.col, got.row);
          err_count++;
        end else begin
          want = cell_results_q.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch: expected avg %0d col %0d row %0d, actual avg %0d col %0d row %0d",
                     $time, want.avg, want.col, want.row, got.avg, got.col, got.row);
            err_count++;
          end
        end
      end
    end
    mismatches <= err_count;
    outstanding <= cell_results_q.size();
  end

endmodule

### tb/area_average_downscaler_unit_tb.sv
`timescale 1ns / 100ps

module area_average_downscaler_unit_tb;
  import aad_pkg::*;

  localparam int PRELOAD_DIM = 16;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SRC_WIDTH;
  logic [7:0]           cfg_data = 8'd0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = KIND_WRITE;
  logic [6:0]           in_src_col = 7'd0;
  logic [6:0]           in_src_row = 7'd0;
  logic [7:0]           in_src_pixel = 8'd0;
  logic [5:0]           in_dst_col = 6'd0;
  logic [5:0]           in_dst_row = 6'd0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_avg_value;
  logic [5:0]           out_echo_col;
  logic [5:0]           out_echo_row;
  int                   mismatches;
  int                   outstanding;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int unsigned          eff_sw = 64;
  int unsigned          eff_sh = 64;
  int unsigned          eff_tw = 64;
  int unsigned          eff_th = 64;

  always #5 clk = ~clk;

  area_average_downscaler_unit u_dut (.*);

  area_average_downscaler_unit_check u_check (.*);

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic put_item(logic kind, logic [6:0] scol, logic [6:0] srow, logic [7:0] pix,
                          logic [5:0] dcol, logic [5:0] drow);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_src_col <= scol;
    in_src_row <= srow;
    in_src_pixel <= pix;
    in_dst_col <= dcol;
    in_dst_row <= drow;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_pixel(logic [6:0] col, logic [6:0] row, logic [7:0] pix);
    put_item(KIND_WRITE, col, row, pix, 6'($urandom_range(63)), 6'($urandom_range(63)));
  endtask

  task automatic request_cell(logic [5:0] col, logic [5:0] row);
    put_item(KIND_REQUEST, 7'($urandom_range(127)), 7'($urandom_range(127)),
             8'($urandom_range(255)), col, row);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int unsigned eff_dim(logic [7:0] v, int unsigned hi);
    if (v == 8'd0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  task automatic set_sizes(logic [7:0] sw, logic [7:0] sh, logic [7:0] tw, logic [7:0] th);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SRC_WIDTH;
    cfg_data <= sw;
    @(posedge clk);
    cfg_index <= CFG_SRC_HEIGHT;
    cfg_data <= sh;
    @(posedge clk);
    cfg_index <= CFG_TGT_WIDTH;
    cfg_data <= tw;
    @(posedge clk);
    cfg_index <= CFG_TGT_HEIGHT;
    cfg_data <= th;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    eff_sw = eff_dim(sw, 128);
    eff_sh = eff_dim(sh, 128);
    eff_tw = eff_dim({1'b0, tw[6:0]}, 64);
    eff_th = eff_dim({1'b0, th[6:0]}, 64);
  endtask

  // In-range requests stay on cells whose source window lies inside the loaded corner.
  task automatic random_items(int n);
    int unsigned safe_w;
    int unsigned safe_h;
    safe_w = (PRELOAD_DIM * eff_tw) / eff_sw;
    safe_h = (PRELOAD_DIM * eff_th) / eff_sh;
    if (safe_w > eff_tw) safe_w = eff_tw;
    if (safe_h > eff_th) safe_h = eff_th;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1) == 1) begin
        if ($urandom_range(9) == 0 && eff_tw < 64) begin
          request_cell(6'($urandom_range(63, eff_tw)), 6'($urandom_range(63)));
        end else begin
          request_cell(6'($urandom_range(safe_w - 1)), 6'($urandom_range(safe_h - 1)));
        end
      end else if ($urandom_range(4) == 0) begin
        write_pixel(7'($urandom_range(127)), 7'($urandom_range(127)),
                    8'($urandom_range(255)));
      end else begin
        write_pixel(7'($urandom_range(eff_sw - 1)), 7'($urandom_range(eff_sh - 1)),
                    8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    logic [7:0] sw, sh, tw, th;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The source store has no reset value, so the corner that requests read is loaded first.
    for (int r = 0; r < PRELOAD_DIM; r++) begin
      for (int c = 0; c < PRELOAD_DIM; c++) begin
        write_pixel(7'(c), 7'(r), 8'($urandom_range(255)));
      end
    end

    write_pixel(0, 0, 8'd0);
    write_pixel(63, 63, 8'd255);
    write_pixel(127, 127, 8'd255);
    write_pixel(0, 63, 8'hAA);
    write_pixel(63, 0, 8'h55);
    write_pixel(126, 126, 8'd17);
    write_pixel(127, 126, 8'd200);
    write_pixel(126, 127, 8'd99);
    request_cell(0, 0);
    request_cell(63, 63);
    request_cell(63, 0);
    request_cell(0, 63);
    drain();
    set_sizes(8'd0, 8'd0, 8'd0, 8'd0);
    request_cell(0, 0);
    request_cell(63, 63);
    request_cell(1, 0);
    drain();
    set_sizes(8'd255, 8'd255, 8'd255, 8'd255);
    request_cell(0, 0);
    request_cell(63, 63);
    drain();
    set_sizes(8'd1, 8'd1, 8'd64, 8'd64);
    request_cell(0, 0);
    request_cell(63, 63);
    drain();
    set_sizes(8'(PRELOAD_DIM), 8'(PRELOAD_DIM), 8'd1, 8'd1);
    request_cell(0, 0);
    request_cell(1, 1);

    for (int p = 0; p < 12; p++) begin
      drain();
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 59;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 59;
        end
        default: begin
          idle_pct = 6;
          stall_pct = 6;
        end
      endcase
      case (p)
        0: set_sizes(8'd100, 8'd37, 8'd30, 8'd11);
        1: set_sizes(8'd17, 8'd50, 8'd64, 8'd7);
        2: set_sizes(8'd255, 8'd255, 8'd127, 8'd127);
        3: set_sizes(8'd128, 8'd96, 8'd40, 8'd33);
        4: set_sizes(8'd0, 8'd0, 8'd0, 8'd0);
        5: set_sizes(8'd1, 8'd1, 8'd64, 8'd64);
        default: begin
          sw = 8'($urandom_range(128, 1));
          sh = 8'($urandom_range(128, 1));
          tw = 8'($urandom_range(64, (32'(sw) + 3) / 4));
          th = 8'($urandom_range(64, (32'(sh) + 3) / 4));
          set_sizes(sw, sh, tw, th);
        end
      endcase
      random_items(40);
    end
    drain();

    if (mismatches == 0) begin
      $display("area_average_downscaler_unit_tb: PASS");
    end else begin
      $display("area_average_downscaler_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("area_average_downscaler_unit_tb: FAIL");
    $finish;
  end

endmodule
